// File: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, constants and helpers of the slot cache planner.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int MAX_ITEMS = 256;
  localparam int ITEM_W    = $clog2(MAX_ITEMS);
  localparam int COUNT_W   = 32;
  localparam int LEN_W     = SLOT_W + 1;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  typedef enum logic [2:0] {
    ST_DUP        = 3'd0,
    ST_HIT        = 3'd1,
    ST_MISS_FREE  = 3'd2,
    ST_MISS_EVICT = 3'd3,
    ST_BAD_ID     = 3'd4,
    ST_TOO_LONG   = 3'd5,
    ST_NO_SLOT    = 3'd6,
    ST_ACK        = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_SLOTS  = 2'd1;
  localparam logic [1:0] REG_ITEMS  = 2'd2;

  typedef struct packed {
    logic              dup;
    logic              hit;
    logic              free;
    logic              any_unpinned;
    logic [SLOT_W-1:0] dup_slot;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] free_slot;
  } match_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// File: rtl/scp_slot_match.sv
// ----------------------------------------------------------------------------
// scp_slot_match
// Parallel tag compare and priority encoders over the slot table.
// ----------------------------------------------------------------------------
module scp_slot_match (
  input  logic [scp_pkg::MAX_SLOTS-1:0][scp_pkg::ITEM_W-1:0] slot_item,
  input  logic [scp_pkg::MAX_SLOTS-1:0]                      slot_valid,
  input  logic [scp_pkg::MAX_SLOTS-1:0]                      slot_pinned,
  input  logic [scp_pkg::MAX_SLOTS-1:0]                      slot_claimed,
  input  logic [scp_pkg::MAX_SLOTS-1:0]                      slot_active,
  input  logic [scp_pkg::ITEM_W-1:0]                         item_id,
  output scp_pkg::match_t                                    match
);
  import scp_pkg::*;

  // scan from the top so the lowest index wins
  always_comb begin
    match = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (slot_active[s] && slot_valid[s] && slot_item[s] == item_id) begin
        match.hit      = 1'b1;
        match.hit_slot = SLOT_W'(s);
        if (slot_claimed[s]) begin
          match.dup      = 1'b1;
          match.dup_slot = SLOT_W'(s);
        end
      end
      if (slot_active[s] && !slot_valid[s] && !slot_pinned[s]) begin
        match.free      = 1'b1;
        match.free_slot = SLOT_W'(s);
      end
      if (slot_active[s] && !slot_pinned[s]) begin
        match.any_unpinned = 1'b1;
      end
    end
  end

endmodule

// File: rtl/slot_cache_planner_lru_lfu_top.sv
// ----------------------------------------------------------------------------
// slot_cache_planner_lru_lfu_top
// Maps item ids onto cache slots with LRU or LFU replacement and pinning.
// ----------------------------------------------------------------------------
// Input stream: in_tuser carries the command (lookup, release, clear), in_tdata
// the item id, request-start flag and release slot. One result per input item
// on the output stream: out_tuser is the status, out_tdata the slot.
// Configuration (policy, active slot count, item count) sits on an APB-style
// port and must be written only while the block is idle; the block does not enforce this.
// Release, clear, duplicate and error items go from S_EVAL straight to S_RESP;
// hits and free misses pass through S_CLAIM first; an eviction walks the slot
// use/recency memory one slot per cycle in S_SCAN before S_CLAIM and S_RESP.
// One item is in flight at a time; the next is taken the cycle after the
// result enters the output register.
// Per-item use counts live in a 256-entry memory with a flop valid bit per
// entry, so reset and the clear command clear only those valid bits.
// If the receiver stalls, the result holds in the output register and a
// following item waits in the block until that register frees up.
// ----------------------------------------------------------------------------
module slot_cache_planner_lru_lfu_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,   // item_id[7:0], request_start[8], release_slot[12:9]
  input  logic [1:0]                   in_tuser,   // command[1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // slot[3:0]
  output logic [2:0]                   out_tuser,  // status[2:0]
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [scp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [scp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [scp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import scp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_SCAN, S_CLAIM, S_RESP} state_t;

  state_t state_r;

  // configuration
  logic       policy_r;
  logic [4:0] slots_in_use_r;
  logic [8:0] items_in_layer_r;
  logic       cfg_wr;

  // item registers
  cmd_t              cmd_r;
  logic [ITEM_W-1:0] id_r;
  logic              start_r;
  logic [SLOT_W-1:0] rel_r;

  // slot table in flops
  logic [MAX_SLOTS-1:0][ITEM_W-1:0] slot_item_r;
  logic [MAX_SLOTS-1:0]             slot_valid_r;
  logic [MAX_SLOTS-1:0]             slot_pinned_r;
  logic [MAX_SLOTS-1:0]             slot_claimed_r;
  logic [MAX_SLOTS-1:0]             slot_active;
  logic [MAX_SLOTS-1:0]             claimed_eff;

  logic [COUNT_W-1:0] clock_r;
  logic [COUNT_W-1:0] clock_eff;
  logic [LEN_W-1:0]   reqlen_r;
  logic [LEN_W-1:0]   reqlen_eff;
  logic [LEN_W-1:0]   n_active;

  // per-item use count memory
  logic [COUNT_W-1:0]   item_mem [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] item_vld_r;
  logic [COUNT_W-1:0]   item_q_r;
  logic [COUNT_W-1:0]   inc_val;
  logic [COUNT_W-1:0]   inc_r;
  logic                 item_we;

  // per-slot {use count, last use} memory
  logic [2*COUNT_W-1:0] slot_mem [MAX_SLOTS];
  logic [2*COUNT_W-1:0] slot_q_r;
  logic [SLOT_W-1:0]    slot_rd_addr;
  logic                 slot_we;

  // eviction scan
  logic [LEN_W-1:0]   rd_cnt_r;
  logic               cmp_vld_r;
  logic [SLOT_W-1:0]  cmp_idx_r;
  logic               best_vld_r;
  logic [SLOT_W-1:0]  best_idx_r;
  logic [COUNT_W-1:0] best_cnt_r;
  logic [COUNT_W-1:0] best_lu_r;
  logic [COUNT_W-1:0] q_cnt;
  logic [COUNT_W-1:0] q_lu;
  logic               better;

  logic [SLOT_W-1:0] claim_slot_r;
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_valid_r;

  match_t match;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_POLICY: cfg_prdata = CFG_DW'(policy_r);
      REG_SLOTS:  cfg_prdata = CFG_DW'(slots_in_use_r);
      REG_ITEMS:  cfg_prdata = CFG_DW'(items_in_layer_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign n_active = (slots_in_use_r > 5'(MAX_SLOTS)) ? LEN_W'(MAX_SLOTS)
                                                    : LEN_W'(slots_in_use_r);

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      slot_active[s] = LEN_W'(s) < n_active;
    end
  end

  // request start takes effect before anything else in the lookup
  assign clock_eff   = start_r ? sat_inc(clock_r) : clock_r;
  assign reqlen_eff  = start_r ? '0 : reqlen_r;
  assign claimed_eff = start_r ? '0 : slot_claimed_r;

  scp_slot_match u_match (
    .slot_item    (slot_item_r),
    .slot_valid   (slot_valid_r),
    .slot_pinned  (slot_pinned_r),
    .slot_claimed (claimed_eff),
    .slot_active  (slot_active),
    .item_id      (id_r),
    .match        (match)
  );

  assign inc_val = sat_inc(item_vld_r[id_r] ? item_q_r : '0);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = 8'(out_slot_r);
  assign out_tuser  = out_status_r;

  assign item_we = (state_r == S_EVAL) && (cmd_r == CMD_LOOKUP) && (reqlen_eff < n_active) &&
                   ({1'b0, id_r} < items_in_layer_r) && !match.dup;
  assign slot_we = (state_r == S_CLAIM);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_q_r <= item_mem[in_tdata[ITEM_W-1:0]];
    end
    if (item_we) begin
      item_mem[id_r] <= inc_val;
    end
  end

  assign slot_rd_addr = rd_cnt_r[SLOT_W-1:0];
  assign q_cnt        = slot_q_r[2*COUNT_W-1:COUNT_W];
  assign q_lu         = slot_q_r[COUNT_W-1:0];
  assign better       = policy_r ? ({q_cnt, q_lu} < {best_cnt_r, best_lu_r})
                                 : (q_lu < best_lu_r);

  always_ff @(posedge clk) begin
    slot_q_r <= slot_mem[slot_rd_addr];
    if (slot_we) begin
      slot_mem[claim_slot_r] <= {inc_r, clock_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      policy_r         <= 1'b0;
      slots_in_use_r   <= 5'd16;
      items_in_layer_r <= 9'd256;
      slot_valid_r     <= '0;
      slot_pinned_r    <= '0;
      slot_claimed_r   <= '0;
      item_vld_r       <= '0;
      clock_r          <= '0;
      reqlen_r         <= '0;
      out_valid_r      <= 1'b0;
      cmp_vld_r        <= 1'b0;
      best_vld_r       <= 1'b0;
      rd_cnt_r         <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_POLICY: policy_r         <= cfg_pwdata[0];
          REG_SLOTS:  slots_in_use_r   <= cfg_pwdata[4:0];
          REG_ITEMS:  items_in_layer_r <= cfg_pwdata[8:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= cmd_t'(in_tuser);
            id_r    <= in_tdata[ITEM_W-1:0];
            start_r <= in_tdata[8];
            rel_r   <= in_tdata[12:9];
            state_r <= S_EVAL;
          end
        end

        S_EVAL: begin
          res_status_r <= ST_ACK;
          res_slot_r   <= '0;
          state_r      <= S_RESP;
          case (cmd_r)
            CMD_RELEASE: slot_pinned_r[rel_r] <= 1'b0;
            CMD_CLEAR: begin
              slot_valid_r   <= '0;
              slot_pinned_r  <= '0;
              slot_claimed_r <= '0;
              item_vld_r     <= '0;
              clock_r        <= '0;
              reqlen_r       <= '0;
            end
            CMD_LOOKUP: begin
              clock_r        <= clock_eff;
              slot_claimed_r <= claimed_eff;
              reqlen_r       <= reqlen_eff;
              if (reqlen_eff >= n_active) begin
                res_status_r <= ST_TOO_LONG;
              end else begin
                reqlen_r <= reqlen_eff + LEN_W'(1);
                if ({1'b0, id_r} >= items_in_layer_r) begin
                  res_status_r <= ST_BAD_ID;
                end else if (match.dup) begin
                  res_status_r <= ST_DUP;
                  res_slot_r   <= match.dup_slot;
                end else begin
                  item_vld_r[id_r] <= 1'b1;
                  inc_r            <= inc_val;
                  if (match.hit) begin
                    res_status_r <= ST_HIT;
                    claim_slot_r <= match.hit_slot;
                    state_r      <= S_CLAIM;
                  end else if (match.free) begin
                    res_status_r <= ST_MISS_FREE;
                    claim_slot_r <= match.free_slot;
                    state_r      <= S_CLAIM;
                  end else if (!match.any_unpinned) begin
                    res_status_r <= ST_NO_SLOT;
                  end else begin
                    res_status_r <= ST_MISS_EVICT;
                    rd_cnt_r     <= '0;
                    cmp_vld_r    <= 1'b0;
                    best_vld_r   <= 1'b0;
                    state_r      <= S_SCAN;
                  end
                end
              end
            end
            default: ;
          endcase
        end

        S_SCAN: begin
          // read one slot per cycle, compare it in the next cycle
          if (rd_cnt_r < n_active) begin
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= rd_cnt_r[SLOT_W-1:0];
            rd_cnt_r  <= rd_cnt_r + LEN_W'(1);
          end else begin
            cmp_vld_r <= 1'b0;
          end
          if (cmp_vld_r && !slot_pinned_r[cmp_idx_r] && (!best_vld_r || better)) begin
            best_vld_r <= 1'b1;
            best_idx_r <= cmp_idx_r;
            best_cnt_r <= q_cnt;
            best_lu_r  <= q_lu;
          end
          if (rd_cnt_r >= n_active && !cmp_vld_r) begin
            claim_slot_r <= best_idx_r;
            res_slot_r   <= best_idx_r;
            state_r      <= S_CLAIM;
          end
        end

        S_CLAIM: begin
          slot_item_r[claim_slot_r]    <= id_r;
          slot_valid_r[claim_slot_r]   <= 1'b1;
          slot_pinned_r[claim_slot_r]  <= 1'b1;
          slot_claimed_r[claim_slot_r] <= 1'b1;
          res_slot_r                   <= claim_slot_r;
          state_r                      <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
